FILE: rtl/sipf_pkg.sv
// ----------------------------------------------------------------------------
// Servo instruction packet framer package
// Shared constants, codes, types and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package sipf_pkg;

  localparam int MAX_DATA_BYTES = 4;
  localparam int PKT_MAX        = 12 + MAX_DATA_BYTES;
  localparam int IDX_W          = $clog2(PKT_MAX);

  localparam logic [7:0]  BROADCAST_ID = 8'hFE;
  localparam logic [15:0] CRC_POLY     = 16'h8005;
  localparam logic [7:0]  HDR_FF       = 8'hFF;
  localparam logic [7:0]  HDR_FD       = 8'hFD;
  localparam logic [7:0]  INSTR_PING   = 8'h01;
  localparam logic [7:0]  INSTR_READ   = 8'h02;
  localparam logic [7:0]  INSTR_WRITE  = 8'h03;

  localparam logic [IDX_W-1:0] POS_HDR0  = IDX_W'(0);
  localparam logic [IDX_W-1:0] POS_HDR1  = IDX_W'(1);
  localparam logic [IDX_W-1:0] POS_HDR2  = IDX_W'(2);
  localparam logic [IDX_W-1:0] POS_HDR3  = IDX_W'(3);
  localparam logic [IDX_W-1:0] POS_ID    = IDX_W'(4);
  localparam logic [IDX_W-1:0] POS_LENL  = IDX_W'(5);
  localparam logic [IDX_W-1:0] POS_LENH  = IDX_W'(6);
  localparam logic [IDX_W-1:0] POS_INSTR = IDX_W'(7);
  localparam logic [IDX_W-1:0] POS_ADDR  = IDX_W'(8);
  localparam logic [IDX_W-1:0] POS_ADDRH = IDX_W'(9);
  localparam logic [IDX_W-1:0] POS_P2    = IDX_W'(10);
  localparam logic [IDX_W-1:0] POS_P3    = IDX_W'(11);
  localparam logic [IDX_W-1:0] BASE_PING = IDX_W'(9);

  typedef enum logic [1:0] {
    REQ_PING  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BCAST_READ = 2'd1,
    ST_BAD_COUNT  = 2'd2
  } status_t;

  typedef struct packed {
    req_t             req;
    logic [7:0]       id;
    logic [7:0]       addr;
    logic [7:0]       cnt;
    logic [31:0]      data;
    logic [15:0]      len;
    logic [IDX_W-1:0] last_idx;
  } cmd_t;

  typedef struct packed {
    logic [7:0] tx;
    logic       is_crc;
    logic       last;
  } gen_out_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/sipf_crc.sv
// ----------------------------------------------------------------------------
// CRC-16 accumulator
// Shared CRC register, cleared per packet and advanced one byte per update.
// ----------------------------------------------------------------------------
module sipf_crc (
  input  logic        clk,
  input  logic        clear,
  input  logic        update,
  input  logic [7:0]  data_byte,
  output logic [15:0] crc
);

  logic [15:0] crc_next;

  always_comb begin
    crc_next = crc;
    if (clear) begin
      crc_next = 16'h0000;
    end else if (update) begin
      crc_next = sipf_pkg::crc_byte(crc, data_byte);
    end
  end

  always_ff @(posedge clk) begin
    crc <= crc_next;
  end

endmodule

FILE: rtl/sipf_byte_gen.sv
// ----------------------------------------------------------------------------
// Packet byte generator
// Selects the packet byte at a given position of the current command.
// ----------------------------------------------------------------------------
module sipf_byte_gen (
  input  sipf_pkg::cmd_t                cmd,
  input  logic [sipf_pkg::IDX_W-1:0]    idx,
  input  logic [15:0]                   crc,
  output sipf_pkg::gen_out_t            gen
);

  logic [sipf_pkg::IDX_W-1:0] crc_lo_idx;
  logic [sipf_pkg::IDX_W-1:0] data_k;
  logic [31:0]                data_sh;

  always_comb begin
    crc_lo_idx = cmd.last_idx - sipf_pkg::IDX_W'(1);
    data_k     = idx - sipf_pkg::POS_P2;
    data_sh    = cmd.data >> {data_k, 3'b000};
    gen.last   = (idx == cmd.last_idx);
    gen.is_crc = (idx == cmd.last_idx) || (idx == crc_lo_idx);
    gen.tx     = 8'h00;
    if (idx == crc_lo_idx) begin
      gen.tx = crc[7:0];
    end else if (idx == cmd.last_idx) begin
      gen.tx = crc[15:8];
    end else begin
      case (idx)
        sipf_pkg::POS_HDR0:  gen.tx = sipf_pkg::HDR_FF;
        sipf_pkg::POS_HDR1:  gen.tx = sipf_pkg::HDR_FF;
        sipf_pkg::POS_HDR2:  gen.tx = sipf_pkg::HDR_FD;
        sipf_pkg::POS_HDR3:  gen.tx = 8'h00;
        sipf_pkg::POS_ID:    gen.tx = cmd.id;
        sipf_pkg::POS_LENL:  gen.tx = cmd.len[7:0];
        sipf_pkg::POS_LENH:  gen.tx = cmd.len[15:8];
        sipf_pkg::POS_INSTR: begin
          case (cmd.req)
            sipf_pkg::REQ_PING:  gen.tx = sipf_pkg::INSTR_PING;
            sipf_pkg::REQ_READ:  gen.tx = sipf_pkg::INSTR_READ;
            default:             gen.tx = sipf_pkg::INSTR_WRITE;
          endcase
        end
        sipf_pkg::POS_ADDR:  gen.tx = cmd.addr;
        sipf_pkg::POS_ADDRH: gen.tx = 8'h00;
        default: begin
          if (cmd.req == sipf_pkg::REQ_READ) begin
            gen.tx = (idx == sipf_pkg::POS_P2) ? cmd.cnt : 8'h00;
          end else begin
            gen.tx = data_sh[7:0];
          end
        end
      endcase
    end
  end

endmodule

FILE: rtl/servo_instruction_packet_framer_top.sv
// ----------------------------------------------------------------------------
// Servo instruction packet framer
// One command in, one instruction packet out, one byte per output transaction.
// Accept registers the command and moves to S_RUN; the first byte is then
// registered onto tx_byte. Bytes: ping 10, read 14, write 12+count, one per
//   cycle unless out_stall holds; set by the single sequencer and shared CRC.
// Errors give one byte; an unused request type gives none. Reset idles.
// ----------------------------------------------------------------------------
module servo_instruction_packet_framer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [7:0]  device_id,
  input  logic [7:0]  reg_address,
  input  logic [7:0]  byte_count,
  input  logic [31:0] data_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  tx_byte,
  output logic        last,
  output logic [1:0]  status
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t                     state, state_next;
  sipf_pkg::cmd_t             cmd, cmd_next;
  sipf_pkg::status_t          err, err_next;
  logic [sipf_pkg::IDX_W-1:0] idx, idx_next;
  logic                       out_valid_next;
  logic [7:0]                 tx_byte_next;
  logic                       last_next;
  logic [1:0]                 status_next;

  sipf_pkg::gen_out_t gen;
  logic [15:0]        crc;
  logic               accept;
  logic               slot;
  logic               emit;
  logic               crc_update;
  logic [7:0]         nparam;
  logic               bad_cnt;

  sipf_byte_gen u_gen (
    .cmd (cmd),
    .idx (idx),
    .crc (crc),
    .gen (gen)
  );

  sipf_crc u_crc (
    .clk       (clk),
    .clear     (accept),
    .update    (crc_update),
    .data_byte (gen.tx),
    .crc       (crc)
  );

  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && (state == S_IDLE);
  assign slot       = !out_valid || !out_stall;
  assign emit       = (state == S_RUN) && slot;
  assign crc_update = emit && (err == sipf_pkg::ST_OK) && !gen.is_crc;
  assign bad_cnt    = (byte_count == 8'h00) || (byte_count > 8'(sipf_pkg::MAX_DATA_BYTES));

  always_comb begin
    case (sipf_pkg::req_t'(req_type))
      sipf_pkg::REQ_PING: nparam = 8'd0;
      sipf_pkg::REQ_READ: nparam = 8'd4;
      default:            nparam = byte_count + 8'd2;
    endcase
  end

  always_comb begin
    state_next     = state;
    cmd_next       = cmd;
    err_next       = err;
    idx_next       = idx;
    out_valid_next = out_valid && out_stall;
    tx_byte_next   = tx_byte;
    last_next      = last;
    status_next    = status;
    if (accept) begin
      cmd_next.req      = sipf_pkg::req_t'(req_type);
      cmd_next.id       = device_id;
      cmd_next.addr     = reg_address;
      cmd_next.cnt      = byte_count;
      cmd_next.data     = data_value;
      cmd_next.len      = 16'(nparam) + 16'd3;
      cmd_next.last_idx = sipf_pkg::BASE_PING + sipf_pkg::IDX_W'(nparam);
      idx_next          = '0;
      err_next          = sipf_pkg::ST_OK;
      if ((req_type == sipf_pkg::REQ_READ) && (device_id == sipf_pkg::BROADCAST_ID)) begin
        err_next = sipf_pkg::ST_BCAST_READ;
      end else if ((req_type == sipf_pkg::REQ_WRITE) && bad_cnt) begin
        err_next = sipf_pkg::ST_BAD_COUNT;
      end
      if (req_type != sipf_pkg::REQ_NONE) begin
        state_next = S_RUN;
      end
    end else if (emit) begin
      out_valid_next = 1'b1;
      if (err != sipf_pkg::ST_OK) begin
        tx_byte_next = 8'h00;
        last_next    = 1'b1;
        status_next  = err;
        state_next   = S_IDLE;
      end else begin
        tx_byte_next = gen.tx;
        last_next    = gen.last;
        status_next  = sipf_pkg::ST_OK;
        idx_next     = idx + sipf_pkg::IDX_W'(1);
        if (gen.last) begin
          state_next = S_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
    cmd     <= cmd_next;
    err     <= err_next;
    idx     <= idx_next;
    tx_byte <= tx_byte_next;
    last    <= last_next;
    status  <= status_next;
  end

endmodule
